### rtl/owsf_pkg.sv
// ----------------------------------------------------------------------------
// owsf_pkg
// Shared types, constants and helpers of the overwriting stamped item queue.
// ----------------------------------------------------------------------------
package owsf_pkg;

	localparam int QUEUE_DEPTH       = 64;
	localparam int MAX_EXTRA_TARGETS = 8;
	localparam int FILL_W            = $clog2(QUEUE_DEPTH + 1);

	localparam int PAYLOAD_W = 64;
	localparam int EXTRA_W   = 4;
	localparam int SEQ_W     = 48;
	localparam int STAMP_W   = 48;
	localparam int DROP_W    = 32;
	localparam int DISC_W    = 7;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_DISCARD = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [EXTRA_W-1:0]   extra;
		logic [SEQ_W-1:0]     seq;
		logic [STAMP_W-1:0]   stamp;
		logic [DROP_W-1:0]    drop_mark;
	} record_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic push;
	} chain_ctrl_t;

	typedef struct packed {
		logic                 ok;
		logic [PAYLOAD_W-1:0] payload;
		logic [EXTRA_W-1:0]   extra;
		logic [SEQ_W-1:0]     seq;
		logic [STAMP_W-1:0]   stamp;
		logic [DROP_W-1:0]    dropped_before;
		logic [DISC_W-1:0]    discarded;
		logic [DROP_W-1:0]    dropped_total;
	} result_t;

	// saturating add onto the drop total
	function automatic logic [DROP_W-1:0] sat_add(input logic [DROP_W-1:0] total,
			input logic [FILL_W-1:0] n);
		logic [DROP_W:0] sum;
		sum = {1'b0, total} + (DROP_W + 1)'(n);
		return sum[DROP_W] ? {DROP_W{1'b1}} : sum[DROP_W-1:0];
	endfunction

endpackage

### rtl/owsf_cell.sv
// ----------------------------------------------------------------------------
// owsf_cell
// One queue slot: holds a record and takes its neighbour's on a shift.
// ----------------------------------------------------------------------------
module owsf_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  owsf_pkg::chain_ctrl_t ctrl,
	input  owsf_pkg::record_t     new_rec,
	input  logic                  left_valid,
	input  logic                  nb_valid,
	input  owsf_pkg::record_t     nb_rec,
	output logic                  valid,
	output owsf_pkg::record_t     rec
);

	logic              valid_q;
	owsf_pkg::record_t rec_q;
	logic              load;

	assign load  = ctrl.push && !ctrl.shift && left_valid && !valid_q;
	assign valid = valid_q;
	assign rec   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nb_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			rec_q <= nb_rec;
		end else if (load) begin
			rec_q <= new_rec;
		end
	end

endmodule

### rtl/owsf_chain.sv
// ----------------------------------------------------------------------------
// owsf_chain
// Row of slots, oldest item in slot zero, shifting towards the head.
// ----------------------------------------------------------------------------
module owsf_chain (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  owsf_pkg::chain_ctrl_t                ctrl,
	input  owsf_pkg::record_t                    new_rec,
	output owsf_pkg::record_t                    head_rec,
	output logic [owsf_pkg::QUEUE_DEPTH-1:0]     valid_vec
);

	owsf_pkg::record_t recs [owsf_pkg::QUEUE_DEPTH];

	for (genvar i = 0; i < owsf_pkg::QUEUE_DEPTH; i++) begin : g_cell
		logic              left_v;
		logic              nb_v;
		owsf_pkg::record_t nb_r;

		if (i == 0) begin : g_first
			assign left_v = 1'b1;
		end else begin : g_rest
			assign left_v = valid_vec[i-1];
		end

		// the last slot is fed by the incoming record on a full push
		if (i == owsf_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign nb_v = ctrl.push;
			assign nb_r = new_rec;
		end else begin : g_mid
			assign nb_v = valid_vec[i+1];
			assign nb_r = recs[i+1];
		end

		owsf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_rec    (new_rec),
			.left_valid (left_v),
			.nb_valid   (nb_v),
			.nb_rec     (nb_r),
			.valid      (valid_vec[i]),
			.rec        (recs[i])
		);
	end

	assign head_rec = recs[0];

endmodule

### rtl/overwrite_oldest_stamped_fifo_unit.sv
// ----------------------------------------------------------------------------
// overwrite_oldest_stamped_fifo_unit
// Bounded queue of stamped records that overwrites its oldest item when full.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command per item: push a
// record, pop the oldest record, or discard everything pending. Every item
// yields exactly one result on the output channel (out_valid / out_stall).
// The result of an item is registered into the output register at the edge
// that accepts it. Throughput is one item per cycle while the receiver does
// not stall; each accepted item updates the slot row (shift, load or clear)
// and the counters together, so that register update sets the rate.
// in_stall rises only while a result waits in the output register and the
// receiver stalls; a new item is taken in the same cycle the waiting result
// leaves. After reset the queue is empty, the sequence counter holds one and
// the drop total is zero; slot contents are not cleared, only their valid
// bits.
// ----------------------------------------------------------------------------
module overwrite_oldest_stamped_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] payload,
	input  logic [3:0]  extra_count,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [63:0] out_payload,
	output logic [3:0]  out_extra_count,
	output logic [47:0] sequence_res,
	output logic [47:0] stamp_ms,
	output logic [31:0] dropped_before,
	output logic [6:0]  discarded,
	output logic [31:0] dropped_total
);

	logic [owsf_pkg::FILL_W-1:0]  fill_q, fill_d;
	logic [owsf_pkg::SEQ_W-1:0]   seq_q, seq_d;
	logic [owsf_pkg::DROP_W-1:0]  drop_q, drop_d;
	logic [owsf_pkg::DROP_W-1:0]  drop_inc1, mark;
	logic                         out_valid_q;
	owsf_pkg::result_t            res, res_q;
	owsf_pkg::chain_ctrl_t        ctrl, ctrl_g;
	owsf_pkg::record_t            new_rec, head_rec;
	logic [owsf_pkg::QUEUE_DEPTH-1:0] valid_vec;
	logic                         in_acc, full;

	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign full      = (fill_q == owsf_pkg::FILL_W'(owsf_pkg::QUEUE_DEPTH));
	assign drop_inc1 = owsf_pkg::sat_add(drop_q, owsf_pkg::FILL_W'(1));
	assign mark      = full ? drop_inc1 : drop_q;

	assign new_rec.payload   = payload;
	assign new_rec.extra     = extra_count;
	assign new_rec.seq       = seq_q;
	assign new_rec.stamp     = now_ms;
	assign new_rec.drop_mark = mark;

	always_comb begin
		res    = '0;
		ctrl   = '0;
		fill_d = fill_q;
		seq_d  = seq_q;
		drop_d = drop_q;
		case (owsf_pkg::cmd_t'(cmd))
			owsf_pkg::CMD_PUSH: begin
				if (extra_count > owsf_pkg::EXTRA_W'(owsf_pkg::MAX_EXTRA_TARGETS)) begin
					drop_d = drop_inc1;
				end else begin
					ctrl.push          = 1'b1;
					ctrl.shift         = full;
					fill_d             = full ? fill_q : fill_q + 1'b1;
					drop_d             = mark;
					seq_d              = seq_q + 1'b1;
					res.ok             = 1'b1;
					res.seq            = seq_q;
					res.stamp          = now_ms;
					res.dropped_before = mark;
				end
			end
			owsf_pkg::CMD_POP: begin
				if (fill_q != '0) begin
					ctrl.shift         = 1'b1;
					fill_d             = fill_q - 1'b1;
					res.ok             = 1'b1;
					res.payload        = head_rec.payload;
					res.extra          = head_rec.extra;
					res.seq            = head_rec.seq;
					res.stamp          = head_rec.stamp;
					res.dropped_before = head_rec.drop_mark;
				end
			end
			owsf_pkg::CMD_DISCARD: begin
				ctrl.clear    = 1'b1;
				fill_d        = '0;
				drop_d        = owsf_pkg::sat_add(drop_q, fill_q);
				res.discarded = owsf_pkg::DISC_W'(fill_q);
			end
			default: begin
			end
		endcase
		res.dropped_total = drop_d;
	end

	assign ctrl_g = in_acc ? ctrl : '0;

	owsf_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_g),
		.new_rec   (new_rec),
		.head_rec  (head_rec),
		.valid_vec (valid_vec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			seq_q       <= owsf_pkg::SEQ_W'(1);
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				fill_q <= fill_d;
				seq_q  <= seq_d;
				drop_q <= drop_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = res_q.ok;
	assign out_payload     = res_q.payload;
	assign out_extra_count = res_q.extra;
	assign sequence_res    = res_q.seq;
	assign stamp_ms        = res_q.stamp;
	assign dropped_before  = res_q.dropped_before;
	assign discarded       = res_q.discarded;
	assign dropped_total   = res_q.dropped_total;

	a_fill_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_q))
		else $error("fill count differs from occupied slots");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= owsf_pkg::FILL_W'(owsf_pkg::QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (cmd == owsf_pkg::CMD_POP) && (fill_q != '0)
		|=> fill_q == $past(fill_q) - 1'b1)
		else $error("pop did not remove one item");

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> drop_q >= $past(drop_q))
		else $error("drop total decreased");

	a_discard_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.discarded != '0) |-> !res_q.ok)
		else $error("discard result flagged ok");

endmodule
